>>> design/ap2rs_pkg.sv
// Package for the aligned power-of-two range splitter.
// Holds the fixed field widths and the queue depth; no dependencies.
`default_nettype none

package ap2rs_pkg;

  // Widths of the channel payload fields.
  localparam int unsigned START_W = 32;
  localparam int unsigned END_W   = 33;
  localparam int unsigned LOG2_W  = 6;

  // Entries in the queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

>>> design/ap2rs_if.sv
// Channel interfaces of the range splitter: range requests in, blocks out.
// Depends on ap2rs_pkg for the field widths.
`default_nettype none

interface ap2rs_in_if;
  logic                               valid;
  logic                               ready;
  logic [ap2rs_pkg::START_W-1:0]      range_start;
  logic [ap2rs_pkg::END_W-1:0]        range_end;
  logic                               is_device;

  modport source (output valid, output range_start, output range_end, output is_device,
                  input ready);
  modport sink   (input valid, input range_start, input range_end, input is_device,
                  output ready);
endinterface

interface ap2rs_out_if;
  logic                               valid;
  logic                               ready;
  logic [ap2rs_pkg::START_W-1:0]      block_base;
  logic [ap2rs_pkg::LOG2_W-1:0]       block_log2_size;
  logic                               block_is_device;
  logic                               last_block;

  modport source (output valid, output block_base, output block_log2_size,
                  output block_is_device, output last_block, input ready);
  modport sink   (input valid, input block_base, input block_log2_size,
                  input block_is_device, input last_block, output ready);
endinterface

`default_nettype wire

>>> design/ap2rs_front.sv
// Front end: takes range requests, clips them to the address space and
// drops empty ranges. Depends on ap2rs_pkg and ap2rs_in_if.
`default_nettype none

module ap2rs_front #(
  parameter int unsigned ADDR_BITS = 32
) (
  ap2rs_in_if.sink                 req_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output logic [2*ADDR_BITS+1:0]   push_data_o
);

  localparam int unsigned EXT_W = ap2rs_pkg::END_W;
  localparam int unsigned EW    = ADDR_BITS + 1;
  localparam logic [EXT_W-1:0] LIMIT = EXT_W'(1) << ADDR_BITS;

  logic [EXT_W-1:0] start_ext;
  logic [EXT_W-1:0] start_sat;
  logic [EXT_W-1:0] end_sat;
  logic             non_empty;

  always_comb begin
    start_ext = EXT_W'(req_i.range_start);
    start_sat = (start_ext > LIMIT) ? LIMIT : start_ext;
    end_sat   = (req_i.range_end > LIMIT) ? LIMIT : req_i.range_end;
    non_empty = start_sat < end_sat;
  end

  // Empty ranges are consumed here and never reach the queue.
  assign req_i.ready  = push_ready_i;
  assign push_valid_o = req_i.valid && non_empty;
  assign push_data_o  = {req_i.is_device, end_sat[EW-1:0], start_sat[ADDR_BITS-1:0]};

endmodule

`default_nettype wire

>>> design/ap2rs_fifo.sv
// Small first-in first-out queue with registered storage.
// Standalone; DEPTH must be a power of two of at least two.
`default_nettype none

module ap2rs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/ap2rs_back.sv
// Back end: walks one clipped range and emits one aligned block per cycle,
// while blk_o is ready, into an output register. Uses ap2rs_pkg, ap2rs_out_if.
`default_nettype none

module ap2rs_back #(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  output logic                     pop_ready_o,
  input  logic [2*ADDR_BITS+1:0]   pop_data_i,
  ap2rs_out_if.source              blk_o
);

  localparam int unsigned AW     = ADDR_BITS;
  localparam int unsigned EW     = ADDR_BITS + 1;
  localparam int unsigned LW     = $clog2(ADDR_BITS + 1);
  localparam int unsigned BASE_W = ap2rs_pkg::START_W;
  localparam int unsigned OUT_LW = ap2rs_pkg::LOG2_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // Trailing zero count; zero counts as aligned to the whole address space.
  function automatic logic [LW-1:0] f_ctz(input logic [AW-1:0] v);
    logic [LW-1:0] n;
    n = LW'(AW);
    for (int i = AW - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = LW'(i);
      end
    end
    return n;
  endfunction

  function automatic logic [LW-1:0] f_flog2(input logic [EW-1:0] v);
    logic [LW-1:0] n;
    n = '0;
    for (int i = 0; i < EW; i++) begin
      if (v[i]) begin
        n = LW'(i);
      end
    end
    return n;
  endfunction

  state_e        state_q, state_d;
  logic [AW-1:0] cur_q;
  logic [EW-1:0] end_q;
  logic          dev_q;
  logic          ov_q, ov_d;
  logic [AW-1:0] obase_q;
  logic [LW-1:0] olog_q;
  logic          odev_q;
  logic          olast_q;

  logic [EW-1:0] remain;
  logic [LW-1:0] align_log2;
  logic [LW-1:0] fit_log2;
  logic [LW-1:0] blk_log2;
  logic [EW-1:0] next_addr;
  logic          is_last;
  logic          busy;
  logic          adv;
  logic          pop;

  always_comb begin
    remain     = end_q - EW'(cur_q);
    align_log2 = f_ctz(cur_q);
    fit_log2   = f_flog2(remain);
    blk_log2   = (align_log2 < fit_log2) ? align_log2 : fit_log2;
    next_addr  = EW'(cur_q) + (EW'(1) << blk_log2);
    // A block never runs past the end, so reaching it marks the last one.
    is_last    = next_addr == end_q;
  end

  assign busy        = state_q == ST_RUN;
  assign adv         = busy && (!ov_q || blk_o.ready);
  assign pop_ready_o = !busy || (adv && is_last);
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (adv && is_last && !pop_valid_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (adv) begin
      ov_d = 1'b1;
    end else if (blk_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= pop_data_i[AW-1:0];
      end_q <= pop_data_i[AW+EW-1:AW];
      dev_q <= pop_data_i[AW+EW];
    end else if (adv) begin
      cur_q <= next_addr[AW-1:0];
    end
    if (adv) begin
      obase_q <= cur_q;
      olog_q  <= blk_log2;
      odev_q  <= dev_q;
      olast_q <= is_last;
    end
  end

  assign blk_o.valid           = ov_q;
  assign blk_o.block_base      = BASE_W'(obase_q);
  assign blk_o.block_log2_size = OUT_LW'(olog_q);
  assign blk_o.block_is_device = odev_q;
  assign blk_o.last_block      = olast_q;

  a_cur_below_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (EW'(cur_q) < end_q))
    else $error("Range walk passed the end address while running.");

  a_block_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> ((EW'(obase_q) & ((EW'(1) << olog_q) - EW'(1))) == '0))
    else $error("Emitted block base is not aligned to its size.");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> ov_q)
    else $error("A computed block did not reach the output register.");

  a_pop_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && busy) |-> is_last)
    else $error("A new range was loaded before the current one finished.");

endmodule

`default_nettype wire

>>> design/aligned_pow2_range_splitter_core.sv
// Aligned power-of-two range splitter. Each transfer on req_i carries a range
// [range_start, range_end) and a device flag; the block clips the range to the
// 2^ADDR_BITS address space and emits on blk_o, in ascending order, the largest
// naturally aligned power-of-two blocks that exactly cover it, with last_block
// set on the final one. Empty ranges produce no output. The front end clips and
// filters requests into a two-entry queue; the back end emits one block per
// cycle while blk_o is ready, a range has 1 to 2*ADDR_BITS-2 blocks, and
// consecutive ranges follow without a gap. The first block of a range passes
// through the queue, the back end's range registers and its output register
// before it appears on blk_o. An empty range is dropped by the front end.
`default_nettype none

module aligned_pow2_range_splitter_core #(
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ap2rs_in_if.sink     req_i,
  ap2rs_out_if.source  blk_o
);

  localparam int unsigned QW = 2 * ADDR_BITS + 2;

  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [QW-1:0] pop_data;

  ap2rs_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ap2rs_fifo #(
    .WIDTH (QW),
    .DEPTH (ap2rs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ap2rs_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .blk_o       (blk_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for aligned_pow2_range_splitter_core: a table of
// directed ranges, then random ranges, with every block checked against the
// table or a local range splitting predictor. Uses ap2rs_pkg and ap2rs_if interfaces.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned RANDOM_RANGES = 100;
  localparam logic [ap2rs_pkg::END_W-1:0] SPACE_END = 33'h1_0000_0000;

  typedef struct packed {
    logic [ap2rs_pkg::START_W-1:0] base;
    logic [ap2rs_pkg::LOG2_W-1:0]  log2_size;
    logic                          is_device;
    logic                          last;
  } block_t;

  // How a directed row gets its expected blocks.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_EMPTY,
    ROW_SINGLE
  } row_kind_e;

  typedef struct packed {
    logic [ap2rs_pkg::START_W-1:0] first_addr;
    logic [ap2rs_pkg::END_W-1:0]   end_addr;
    logic                          is_device;
    row_kind_e                     kind;
    logic [ap2rs_pkg::LOG2_W-1:0]  log2_size;
  } range_row_t;

  localparam range_row_t DIRECTED_ROWS [20] = '{
    '{32'h0000_0000, SPACE_END,          1'b0, ROW_SINGLE,  6'd32},
    '{32'h0000_0000, SPACE_END,          1'b1, ROW_SINGLE,  6'd32},
    '{32'h0000_0000, 33'h0_0000_0001,    1'b0, ROW_SINGLE,  6'd0},
    '{32'hFFFF_FFFF, SPACE_END,          1'b1, ROW_SINGLE,  6'd0},
    '{32'h8000_0000, SPACE_END,          1'b0, ROW_SINGLE,  6'd31},
    '{32'h0000_0005, 33'h0_0000_0005,    1'b0, ROW_EMPTY,   6'd0},
    '{32'h0000_000A, 33'h0_0000_0003,    1'b1, ROW_EMPTY,   6'd0},
    '{32'hFFFF_FFFF, 33'h1_FFFF_FFFF,    1'b1, ROW_SINGLE,  6'd0},
    '{32'h0000_0000, 33'h1_FFFF_FFFF,    1'b0, ROW_SINGLE,  6'd32},
    '{32'hFFFF_FFFF, 33'h0_0000_0000,    1'b0, ROW_EMPTY,   6'd0},
    '{32'h0000_0001, 33'h0_FFFF_FFFF,    1'b1, ROW_PREDICT, 6'd0},
    '{32'h0000_0001, SPACE_END,          1'b0, ROW_PREDICT, 6'd0},
    '{32'h0000_1000, 33'h0_0000_2000,    1'b1, ROW_SINGLE,  6'd12},
    '{32'h0000_0000, 33'h0_7FFF_FFFF,    1'b0, ROW_PREDICT, 6'd0},
    '{32'h0000_0003, SPACE_END,          1'b1, ROW_PREDICT, 6'd0},
    '{32'h1234_5678, 33'h0_9ABC_DEF0,    1'b1, ROW_PREDICT, 6'd0},
    '{32'hAAAA_AAAA, 33'h0_D555_5555,    1'b0, ROW_PREDICT, 6'd0},
    '{32'h0000_0001, 33'h0_0000_0002,    1'b1, ROW_SINGLE,  6'd0},
    '{32'h0000_0100, 33'h0_0000_0180,    1'b0, ROW_SINGLE,  6'd7},
    '{32'h0000_0006, 33'h1_8000_0000,    1'b1, ROW_PREDICT, 6'd0}
  };

  logic clk_i;
  logic rst_ni;

  ap2rs_in_if  req ();
  ap2rs_out_if blk ();

  aligned_pow2_range_splitter_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .blk_o  (blk)
  );

  block_t      pending_blocks [$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long one; always back-to-back while no_idle is set.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Splits [first_addr, end_addr) into aligned power-of-two blocks and queues them.
  function automatic void split_range(input logic [ap2rs_pkg::START_W-1:0] first_addr,
                                      input logic [ap2rs_pkg::END_W-1:0] end_addr,
                                      input logic is_device);
    logic [63:0] cur;
    logic [63:0] stop;
    logic [63:0] remain;
    int unsigned align_bits;
    int unsigned fit_bits;
    int unsigned size_bits;
    block_t      blk_exp;
    cur  = {32'b0, first_addr};
    stop = (end_addr > SPACE_END) ? {31'b0, SPACE_END} : {31'b0, end_addr};
    while (cur < stop) begin
      remain = stop - cur;
      // Address zero is aligned to every size, so it is capped at the space width.
      align_bits = 0;
      while (align_bits < 32 && cur[align_bits] == 1'b0) align_bits++;
      fit_bits = 0;
      while (fit_bits < 63 && (remain >> (fit_bits + 1)) != 0) fit_bits++;
      size_bits = (align_bits < fit_bits) ? align_bits : fit_bits;
      blk_exp.base      = cur[ap2rs_pkg::START_W-1:0];
      blk_exp.log2_size = size_bits[ap2rs_pkg::LOG2_W-1:0];
      blk_exp.is_device = is_device;
      cur = cur + (64'd1 << size_bits);
      blk_exp.last      = (cur >= stop);
      pending_blocks.push_back(blk_exp);
    end
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t: MISMATCH %s", $realtime, what);
  endtask

  // Offers one range after a random gap and holds it until the transfer.
  task automatic send_range(input logic [ap2rs_pkg::START_W-1:0] first_addr,
                            input logic [ap2rs_pkg::END_W-1:0] end_addr,
                            input logic is_device,
                            input row_kind_e kind,
                            input logic [ap2rs_pkg::LOG2_W-1:0] log2_size);
    int unsigned gap;
    block_t      blk_exp;
    gap = pick_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.range_start <= first_addr;
    req.range_end   <= end_addr;
    req.is_device   <= is_device;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    case (kind)
      ROW_SINGLE: begin
        blk_exp = '{first_addr, log2_size, is_device, 1'b1};
        pending_blocks.push_back(blk_exp);
      end
      ROW_EMPTY: begin
      end
      default: begin
        split_range(first_addr, end_addr, is_device);
      end
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_random_range();
    logic [ap2rs_pkg::START_W-1:0] first_addr;
    logic [ap2rs_pkg::END_W-1:0]   end_addr;
    int unsigned                   k;
    first_addr = $urandom();
    case ($urandom_range(0, 9))
      0: end_addr = {1'($urandom_range(0, 1)), 32'($urandom())};
      1, 2: end_addr = {1'b0, first_addr} + 33'($urandom_range(1, 300));
      3: begin
        k = $urandom_range(0, 31);
        first_addr = first_addr & ~((32'd1 << k) - 32'd1);
        end_addr = {1'b0, first_addr} + 33'($urandom_range(1, 3)) * (33'd1 << k);
      end
      4: begin
        first_addr = '0;
        end_addr = {1'($urandom_range(0, 1)), 32'($urandom())};
      end
      5: end_addr = SPACE_END + 33'($urandom());
      6: end_addr = {1'b0, first_addr} - 33'($urandom_range(0, 1000));
      default: end_addr = {1'b0, first_addr} + 33'($urandom());
    endcase
    send_range(first_addr, end_addr, 1'($urandom_range(0, 1)), ROW_PREDICT, '0);
  endtask

  // Stimulus and end of run.
  initial begin
    error_count = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    req.valid       <= 1'b0;
    req.range_start <= '0;
    req.range_end   <= '0;
    req.is_device   <= 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (DIRECTED_ROWS[i]) begin
      send_range(DIRECTED_ROWS[i].first_addr, DIRECTED_ROWS[i].end_addr,
                 DIRECTED_ROWS[i].is_device, DIRECTED_ROWS[i].kind,
                 DIRECTED_ROWS[i].log2_size);
    end
    for (int unsigned n = 0; n < RANDOM_RANGES; n++) begin
      // Every third stretch of 25 ranges runs with both sides at full rate.
      no_idle = ((n / 25) % 3 == 1);
      send_random_range();
    end
    no_idle = 1'b0;
    req.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Output back-pressure.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    blk.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        blk.ready <= 1'b0;
        stall_left--;
      end else begin
        blk.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Block checker.
  always @(posedge clk_i) begin
    block_t blk_exp;
    if (rst_ni && blk.valid === 1'b1 && blk.ready === 1'b1) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected block base=%h log2=%0d",
                                  blk.block_base, blk.block_log2_size));
      end else begin
        blk_exp = pending_blocks.pop_front();
        if (blk.block_base !== blk_exp.base)
          report_mismatch($sformatf("block_base got %h expected %h",
                                    blk.block_base, blk_exp.base));
        if (blk.block_log2_size !== blk_exp.log2_size)
          report_mismatch($sformatf("block_log2_size got %0d expected %0d at base %h",
                                    blk.block_log2_size, blk_exp.log2_size, blk_exp.base));
        if (blk.block_is_device !== blk_exp.is_device)
          report_mismatch($sformatf("block_is_device got %b expected %b at base %h",
                                    blk.block_is_device, blk_exp.is_device, blk_exp.base));
        if (blk.last_block !== blk_exp.last)
          report_mismatch($sformatf("last_block got %b expected %b at base %h",
                                    blk.last_block, blk_exp.last, blk_exp.base));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

>>> files.f
design/ap2rs_pkg.sv
design/ap2rs_if.sv
design/ap2rs_front.sv
design/ap2rs_fifo.sv
design/ap2rs_back.sv
design/aligned_pow2_range_splitter_core.sv
tb/sv/testbench.sv
